@@ sv/multi_slot_countdown_timer_table_defines.svh @@
// ---------------------------------------------------------------------------
// Timer table assertion macros
// Concurrent assertion wrappers; they compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef MULTI_SLOT_COUNTDOWN_TIMER_TABLE_DEFINES_SVH
`define MULTI_SLOT_COUNTDOWN_TIMER_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define MSTT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer table assertion failed");
`define MSTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer table assertion failed");
`else
`define MSTT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MSTT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/mstt_pkg.sv @@
// ---------------------------------------------------------------------------
// Timer table package
// Shared types, codes and constants of the countdown timer table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mstt_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int SLOT_FIELD_W   = 8;
    localparam int DELAY_W        = 16;
    localparam int TAG_W          = 16;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [1:0] {
        ACT_ADD     = 2'd0,
        ACT_CANCEL  = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_TICK    = 2'd3
    } act_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_NOSPACE   = 3'd2,
        ST_BUSY      = 3'd3,
        ST_CANCELLED = 3'd4,
        ST_EXPIRED   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        COND_RUNNING   = 2'd0,
        COND_DONE      = 2'd1,
        COND_CANCELLED = 2'd2
    } cond_t;

    typedef struct packed {
        act_t                    op;
        logic                    idx_ok;
        logic [DELAY_W-1:0]      delay;
        logic [TAG_W-1:0]        tag;
        logic [SLOT_FIELD_W-1:0] slot;
    } cmd_t;

    typedef struct packed {
        cond_t              cond;
        logic [DELAY_W-1:0] remaining;
        logic [TAG_W-1:0]   tag;
    } slot_entry_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_EVAL,
        BK_RESP,
        BK_TRD,
        BK_TEXEC,
        BK_TFLUSH
    } back_state_t;

endpackage

@@ sv/mstt_ifs.sv @@
// ---------------------------------------------------------------------------
// Timer table channels
// Valid/ready request and response interfaces.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mstt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] delay_ticks;
    logic [15:0] job_tag;
    logic [7:0]  slot_index;

    modport source (output valid, action, delay_ticks, job_tag, slot_index, input ready);
    modport sink   (input valid, action, delay_ticks, job_tag, slot_index, output ready);
endinterface

interface mstt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  result_slot;
    logic [15:0] result_tag;
    logic        last_of_run;

    modport source (output valid, status, result_slot, result_tag, last_of_run, input ready);
    modport sink   (input valid, status, result_slot, result_tag, last_of_run, output ready);
endinterface

@@ sv/mstt_ram.sv @@
// ---------------------------------------------------------------------------
// Timer table RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mstt_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/mstt_front.sv @@
// ---------------------------------------------------------------------------
// Timer table front end
// Accepts requests, checks the slot index and queues commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mstt_front #(
    parameter int SLOT_COUNT = mstt_pkg::SLOT_COUNT_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    mstt_req_if.sink       req,
    output mstt_pkg::cmd_t cmd,
    output logic           cmd_valid,
    input  logic           cmd_take
);

    localparam int QPTR_W = $clog2(mstt_pkg::QUEUE_DEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    mstt_pkg::cmd_t    q_reg [mstt_pkg::QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    mstt_pkg::cmd_t    cls;
    logic              push;
    logic              pop;

    always_comb
    begin
        cls.op     = mstt_pkg::act_t'(req.action);
        cls.idx_ok = ({1'b0, req.slot_index} < 9'(SLOT_COUNT));
        cls.delay  = req.delay_ticks;
        cls.tag    = req.job_tag;
        cls.slot   = req.slot_index;
    end

    assign req.ready = (cnt_reg != QCNT_W'(mstt_pkg::QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign pop       = cmd_take && cmd_valid;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ sv/mstt_back.sv @@
// ---------------------------------------------------------------------------
// Timer table back end
// Executes add, cancel, release and tick against the slot table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mstt_back #(
    parameter int SLOT_COUNT = mstt_pkg::SLOT_COUNT_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  mstt_pkg::cmd_t cmd,
    input  logic           cmd_valid,
    output logic           cmd_take,
    mstt_rsp_if.source     rsp
);

    localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
    localparam int SF_W    = mstt_pkg::SLOT_FIELD_W;
    localparam int TAG_W   = mstt_pkg::TAG_W;
    localparam int DELAY_W = mstt_pkg::DELAY_W;
    localparam int ENT_W   = $bits(mstt_pkg::slot_entry_t);

    mstt_pkg::back_state_t state_reg, state_next;
    mstt_pkg::cmd_t        cmd_reg, cmd_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [SLOT_COUNT-1:0] in_use_reg, in_use_next;
    mstt_pkg::status_t     res_status_reg, res_status_next;
    logic [SF_W-1:0]       res_slot_reg, res_slot_next;
    logic                  hold_valid_reg, hold_valid_next;
    logic [SF_W-1:0]       hold_slot_reg, hold_slot_next;
    logic [TAG_W-1:0]      hold_tag_reg, hold_tag_next;
    logic                  out_valid_reg, out_valid_next;
    mstt_pkg::status_t     out_status_reg, out_status_next;
    logic [SF_W-1:0]       out_slot_reg, out_slot_next;
    logic [TAG_W-1:0]      out_tag_reg, out_tag_next;
    logic                  out_last_reg, out_last_next;

    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_waddr;
    mstt_pkg::slot_entry_t ram_wentry;
    logic                  ram_re;
    logic [SLOT_W-1:0]     ram_raddr;
    logic [ENT_W-1:0]      ram_rdata;
    mstt_pkg::slot_entry_t rd;

    logic [SLOT_W-1:0]     head_idx;
    logic [SLOT_W-1:0]     cmd_idx;
    logic [SLOT_W-1:0]     cnt_idx;
    logic                  cnt_end;
    logic                  out_free;

    mstt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd       = mstt_pkg::slot_entry_t'(ram_rdata);
    assign head_idx = cmd.slot[SLOT_W-1:0];
    assign cmd_idx  = cmd_reg.slot[SLOT_W-1:0];
    assign cnt_idx  = cnt_reg[SLOT_W-1:0];
    assign cnt_end  = (cnt_reg == CNT_W'(SLOT_COUNT));
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        cnt_next        = cnt_reg;
        in_use_next     = in_use_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        hold_valid_next = hold_valid_reg;
        hold_slot_next  = hold_slot_reg;
        hold_tag_next   = hold_tag_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_tag_next    = out_tag_reg;
        out_last_next   = out_last_reg;
        cmd_take        = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = cmd_idx;
        ram_wentry      = rd;
        ram_re          = 1'b0;
        ram_raddr       = cnt_idx;

        case (state_reg)
            mstt_pkg::BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take = 1'b1;
                    cmd_next = cmd;
                    cnt_next = '0;
                    case (cmd.op)
                        mstt_pkg::ACT_ADD:
                        begin
                            state_next = mstt_pkg::BK_SCAN;
                        end
                        mstt_pkg::ACT_CANCEL, mstt_pkg::ACT_RELEASE:
                        begin
                            if (!cmd.idx_ok || !in_use_reg[head_idx])
                            begin
                                res_status_next = mstt_pkg::ST_INVALID;
                                res_slot_next   = '0;
                                state_next      = mstt_pkg::BK_RESP;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = head_idx;
                                state_next = mstt_pkg::BK_EVAL;
                            end
                        end
                        mstt_pkg::ACT_TICK:
                        begin
                            hold_valid_next = 1'b0;
                            state_next      = mstt_pkg::BK_TRD;
                        end
                        default:
                        begin
                            state_next = mstt_pkg::BK_IDLE;
                        end
                    endcase
                end
            end

            mstt_pkg::BK_SCAN:
            begin
                if (cnt_end)
                begin
                    res_status_next = mstt_pkg::ST_NOSPACE;
                    res_slot_next   = '0;
                    state_next      = mstt_pkg::BK_RESP;
                end
                else if (!in_use_reg[cnt_idx])
                begin
                    ram_we               = 1'b1;
                    ram_waddr            = cnt_idx;
                    ram_wentry.cond      = mstt_pkg::COND_RUNNING;
                    ram_wentry.remaining = cmd_reg.delay;
                    ram_wentry.tag       = cmd_reg.tag;
                    in_use_next[cnt_idx] = 1'b1;
                    res_status_next      = mstt_pkg::ST_OK;
                    res_slot_next        = SF_W'(cnt_idx);
                    state_next           = mstt_pkg::BK_RESP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            mstt_pkg::BK_EVAL:
            begin
                res_slot_next = '0;
                state_next    = mstt_pkg::BK_RESP;
                if (cmd_reg.op == mstt_pkg::ACT_CANCEL)
                begin
                    if (rd.cond == mstt_pkg::COND_DONE)
                    begin
                        res_status_next = mstt_pkg::ST_BUSY;
                    end
                    else if (rd.cond != mstt_pkg::COND_RUNNING)
                    begin
                        res_status_next = mstt_pkg::ST_CANCELLED;
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        ram_wentry.cond = mstt_pkg::COND_CANCELLED;
                        res_status_next = mstt_pkg::ST_OK;
                    end
                end
                else
                begin
                    if (rd.cond == mstt_pkg::COND_RUNNING)
                    begin
                        res_status_next = mstt_pkg::ST_INVALID;
                    end
                    else
                    begin
                        in_use_next[cmd_idx] = 1'b0;
                        res_status_next      = mstt_pkg::ST_OK;
                    end
                end
            end

            mstt_pkg::BK_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_tag_next    = '0;
                    out_last_next   = 1'b1;
                    state_next      = mstt_pkg::BK_IDLE;
                end
            end

            mstt_pkg::BK_TRD:
            begin
                if (cnt_end)
                begin
                    state_next = mstt_pkg::BK_TFLUSH;
                end
                else if (!in_use_reg[cnt_idx])
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = mstt_pkg::BK_TEXEC;
                end
            end

            mstt_pkg::BK_TEXEC:
            begin
                ram_waddr = cnt_idx;
                if (rd.cond != mstt_pkg::COND_RUNNING)
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = mstt_pkg::BK_TRD;
                end
                else if (rd.remaining <= DELAY_W'(1))
                begin
                    // previous expiry goes out as not-last once another one is found
                    if (!hold_valid_reg || out_free)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = mstt_pkg::ST_EXPIRED;
                            out_slot_next   = hold_slot_reg;
                            out_tag_next    = hold_tag_reg;
                            out_last_next   = 1'b0;
                        end
                        hold_valid_next      = 1'b1;
                        hold_slot_next       = SF_W'(cnt_idx);
                        hold_tag_next        = rd.tag;
                        ram_we               = 1'b1;
                        ram_wentry.cond      = mstt_pkg::COND_DONE;
                        ram_wentry.remaining = '0;
                        cnt_next             = cnt_reg + 1'b1;
                        state_next           = mstt_pkg::BK_TRD;
                    end
                end
                else
                begin
                    ram_we               = 1'b1;
                    ram_wentry.remaining = rd.remaining - 1'b1;
                    cnt_next             = cnt_reg + 1'b1;
                    state_next           = mstt_pkg::BK_TRD;
                end
            end

            mstt_pkg::BK_TFLUSH:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = mstt_pkg::BK_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = mstt_pkg::ST_EXPIRED;
                    out_slot_next   = hold_slot_reg;
                    out_tag_next    = hold_tag_reg;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = mstt_pkg::BK_IDLE;
                end
            end

            default:
            begin
                state_next = mstt_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mstt_pkg::BK_IDLE;
            cnt_reg        <= '0;
            in_use_reg     <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            in_use_reg     <= in_use_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        hold_slot_reg  <= hold_slot_next;
        hold_tag_reg   <= hold_tag_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_tag_reg    <= out_tag_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.result_slot = out_slot_reg;
    assign rsp.result_tag  = out_tag_reg;
    assign rsp.last_of_run = out_last_reg;

endmodule

@@ sv/multi_slot_countdown_timer_table.sv @@
// Add: the back end scans up from slot 0 in BK_SCAN for the lowest free slot, or
//   reports no space when full; cancel and release read the slot in BK_EVAL unless it is invalid.
// Tick: BK_TRD skips free slots and reads each used slot through the single RAM read
//   port, BK_TEXEC updates it, and BK_TFLUSH sends the last expiry; responses may stall.
// Throughput: one command at a time in the back end; the front queue holds two.
// Reset: all slots free, queue and output empty; slot RAM needs no clearing.
`timescale 1ns / 1ps
`include "multi_slot_countdown_timer_table_defines.svh"

// ---------------------------------------------------------------------------
// Countdown timer table
// Timer slots with add, cancel, release and a shared tick that reports expiries.
// ---------------------------------------------------------------------------
module multi_slot_countdown_timer_table #(
    parameter int SLOT_COUNT = mstt_pkg::SLOT_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mstt_req_if.sink   req,
    mstt_rsp_if.source rsp
);

    mstt_pkg::cmd_t cmd;
    logic           cmd_valid;
    logic           cmd_take;

    mstt_front #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take)
    );

    mstt_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .rsp       (rsp)
    );

    `MSTT_ASSERT_IMPL(a_take_needs_cmd, clk, rst_n, cmd_take, cmd_valid)
    `MSTT_ASSERT_IMPL(a_single_result, clk, rst_n,
        rsp.valid && (rsp.status != mstt_pkg::ST_EXPIRED),
        rsp.last_of_run && (rsp.result_tag == 16'd0))
    `MSTT_ASSERT_IMPL(a_expiry_slot, clk, rst_n,
        rsp.valid && (rsp.status == mstt_pkg::ST_EXPIRED),
        int'(rsp.result_slot) < SLOT_COUNT)
    `MSTT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp.valid && !rsp.ready,
        rsp.valid && $stable(rsp.status) && $stable(rsp.result_slot)
        && $stable(rsp.result_tag) && $stable(rsp.last_of_run))

endmodule

@@ tb/sv/tb.sv @@
// ---------------------------------------------------------------------------
// Countdown timer table testbench
// Drives add, cancel, release and tick commands through the request channel,
// predicts every response with a cycle-free model of the slot table, and
// checks each response transfer in order under random stalls on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import mstt_pkg::*;

    localparam int SLOTS        = SLOT_COUNT_DEF;
    localparam int RANDOM_ITEMS = 230;
    localparam int QUIET_ITEMS  = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        status_t     status;
        logic [7:0]  slot;
        logic [15:0] tag;
        logic        last;
    } rsp_item_t;

    class timer_table_model;
        bit          in_use [SLOTS];
        cond_t       cond   [SLOTS];
        logic [15:0] left   [SLOTS];
        logic [15:0] tag    [SLOTS];
        rsp_item_t   expected_rsp[$];
        int          errors;

        function void push_rsp(status_t st, int slot, logic [15:0] tg, bit lst);
            rsp_item_t r;
            r.status = st;
            r.slot   = 8'(slot);
            r.tag    = tg;
            r.last   = lst;
            expected_rsp.push_back(r);
        endfunction

        function void apply_cmd(act_t op, logic [15:0] dly, logic [15:0] tg,
                                logic [7:0] idx);
            int n;
            n = 0;
            case (op)
                ACT_ADD:
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!in_use[i])
                        begin
                            in_use[i] = 1'b1;
                            cond[i]   = COND_RUNNING;
                            left[i]   = dly;
                            tag[i]    = tg;
                            push_rsp(ST_OK, i, 16'h0, 1'b1);
                            return;
                        end
                    end
                    push_rsp(ST_NOSPACE, 0, 16'h0, 1'b1);
                end
                ACT_CANCEL:
                begin
                    if (idx >= SLOTS || !in_use[idx])
                        push_rsp(ST_INVALID, 0, 16'h0, 1'b1);
                    else if (cond[idx] == COND_DONE)
                        push_rsp(ST_BUSY, 0, 16'h0, 1'b1);
                    else if (cond[idx] != COND_RUNNING)
                        push_rsp(ST_CANCELLED, 0, 16'h0, 1'b1);
                    else
                    begin
                        cond[idx] = COND_CANCELLED;
                        push_rsp(ST_OK, 0, 16'h0, 1'b1);
                    end
                end
                ACT_RELEASE:
                begin
                    if (idx >= SLOTS || !in_use[idx] || cond[idx] == COND_RUNNING)
                        push_rsp(ST_INVALID, 0, 16'h0, 1'b1);
                    else
                    begin
                        in_use[idx] = 1'b0;
                        push_rsp(ST_OK, 0, 16'h0, 1'b1);
                    end
                end
                default:
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (in_use[i] && cond[i] == COND_RUNNING)
                        begin
                            if (left[i] <= 16'd1)
                            begin
                                left[i] = 16'd0;
                                cond[i] = COND_DONE;
                                push_rsp(ST_EXPIRED, i, tag[i], 1'b0);
                                n++;
                            end
                            else
                                left[i] = left[i] - 16'd1;
                        end
                    end
                    if (n > 0)
                        expected_rsp[expected_rsp.size() - 1].last = 1'b1;
                end
            endcase
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        function void check_rsp(logic [2:0] st, logic [7:0] sl, logic [15:0] tg,
                                logic lst);
            rsp_item_t want;
            if (expected_rsp.size() == 0)
            begin
                flag($sformatf("unexpected response at %0t: status %0d slot %0d tag %h",
                               $time, st, sl, tg));
                return;
            end
            want = expected_rsp.pop_front();
            if (st !== want.status || sl !== want.slot || tg !== want.tag ||
                lst !== want.last)
                flag($sformatf({"mismatch at %0t: expected status %0d slot %0d tag %h ",
                                "last %0d, got status %0d slot %0d tag %h last %0d"},
                               $time, want.status, want.slot, want.tag, want.last,
                               st, sl, tg, lst));
        endfunction

        // random slot in the wanted condition, or any slot if none
        function int pick_slot(cond_t want_cond);
            int hits[$];
            for (int i = 0; i < SLOTS; i++)
                if (in_use[i] && cond[i] == want_cond)
                    hits.push_back(i);
            if (hits.size() == 0)
                return $urandom_range(0, SLOTS - 1);
            return hits[$urandom_range(0, hits.size() - 1)];
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   quiet;
    bit   hold_go;
    bit   hold_done;
    int   cycles;

    timer_table_model tbl = new;

    mstt_req_if req_ch();
    mstt_rsp_if rsp_ch();

    multi_slot_countdown_timer_table #(
        .SLOT_COUNT(SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // transfer monitor: commands update the model, responses are checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                tbl.apply_cmd(act_t'(req_ch.action), req_ch.delay_ticks,
                              req_ch.job_tag, req_ch.slot_index);
            if (rsp_ch.valid && rsp_ch.ready)
                tbl.check_rsp(rsp_ch.status, rsp_ch.result_slot, rsp_ch.result_tag,
                              rsp_ch.last_of_run);
        end
    end

    // response side back-pressure
    initial
    begin
        rsp_ch.ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_go && !hold_done)
            begin
                rsp_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            else
            begin
                rsp_ch.ready = 1'b1;
                repeat ($urandom_range(1, 30)) @(negedge clk);
            end
        end
    end

    task automatic send_cmd(act_t op, logic [15:0] dly, logic [15:0] tg,
                            logic [7:0] idx);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        req_ch.action      = op;
        req_ch.delay_ticks = dly;
        req_ch.job_tag     = tg;
        req_ch.slot_index  = idx;
        req_ch.valid       = 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_cmd();
        int          r;
        logic [15:0] dly;
        logic [7:0]  idx;
        act_t        op;
        cond_t       freeable;
        r   = $urandom_range(0, 99);
        idx = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 19))
            0:       dly = 16'($urandom);
            1, 2, 3: dly = 16'($urandom_range(0, 40));
            default: dly = 16'($urandom_range(0, 4));
        endcase
        if (r < 30)
            op = ACT_ADD;
        else if (r < 55)
            op = ACT_TICK;
        else if (r < 72)
        begin
            op = ACT_CANCEL;
            if ($urandom_range(0, 3) != 0)
                idx = 8'(tbl.pick_slot(COND_RUNNING));
        end
        else if (r < 92)
        begin
            op       = ACT_RELEASE;
            freeable = $urandom_range(0, 1) ? COND_DONE : COND_CANCELLED;
            if ($urandom_range(0, 3) != 0)
                idx = 8'(tbl.pick_slot(freeable));
        end
        else
            op = act_t'($urandom_range(0, 3));
        send_cmd(op, dly, 16'($urandom), idx);
    endtask

    initial
    begin
        req_ch.valid       = 1'b0;
        req_ch.action      = ACT_TICK;
        req_ch.delay_ticks = 16'h0;
        req_ch.job_tag     = 16'h0;
        req_ch.slot_index  = 8'h0;
        rst_n              = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, bad indexes, delay extremes, state errors
        send_cmd(ACT_TICK,    16'h0000, 16'h0000, 8'd0);
        send_cmd(ACT_CANCEL,  16'h0000, 16'h0000, 8'd0);
        send_cmd(ACT_RELEASE, 16'hFFFF, 16'hFFFF, 8'd255);
        send_cmd(ACT_CANCEL,  16'h0000, 16'h0000, 8'd16);
        send_cmd(ACT_ADD,     16'h0000, 16'hFFFF, 8'd0);
        send_cmd(ACT_ADD,     16'h0001, 16'h0000, 8'd255);
        send_cmd(ACT_ADD,     16'hFFFF, 16'hA5A5, 8'd0);
        send_cmd(ACT_ADD,     16'h0002, 16'h1234, 8'd0);
        send_cmd(ACT_RELEASE, 16'h0000, 16'h0000, 8'd3);
        send_cmd(ACT_CANCEL,  16'h0000, 16'h0000, 8'd3);
        send_cmd(ACT_CANCEL,  16'h0000, 16'h0000, 8'd3);
        send_cmd(ACT_TICK,    16'h0000, 16'h0000, 8'd0);
        send_cmd(ACT_CANCEL,  16'h0000, 16'h0000, 8'd0);
        send_cmd(ACT_RELEASE, 16'h0000, 16'h0000, 8'd0);
        send_cmd(ACT_RELEASE, 16'h0000, 16'h0000, 8'd3);
        // fill the table, one add past full, then a tick with many expiries
        for (int k = 0; k < 15; k++)
            send_cmd(ACT_ADD, 16'(k % 3), 16'(16'h0100 + k), 8'(k));
        send_cmd(ACT_TICK, 16'h0000, 16'h0000, 8'd0);

        hold_go = 1'b1;
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            send_random_cmd();
        end
        req_ch.valid = 1'b0;

        while (tbl.expected_rsp.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (tbl.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
